// File: rtl/gmef_pkg.sv
// Shared types, widths and codes for the greedy max-edge frontier growth block.
`timescale 1ns / 1ps
`default_nettype none

package gmef_pkg;

    // Default store depths
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 63;
    localparam int WT_W     = 32;
    localparam int ROOT_W   = 6;
    localparam int LIMIT_W  = 7;
    localparam int NIDX_W   = 6;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;

    // Result list: at most 64 chosen nodes per selection
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    // Input item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_NODE = 2'd0,
        CMD_LOAD_EDGE = 2'd1,
        CMD_START     = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_ROOT_BAD = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_LOOK = 3'd1,
        S_CLR  = 3'd2,
        S_NEXT = 3'd3,
        S_SCAN = 3'd4,
        S_RD   = 3'd5,
        S_OUT  = 3'd6
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic node_wr;
        logic ovf_set;
        logic clr_all;
        logic start_take;
        logic edge_take;
        logic look_run;
        logic edge_wr;
        logic sweep_run;
        logic scan_start;
        logic scan_run;
        logic pick;
        logic out_rd;
        logic out_next;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic node_full;
        logic edge_full;
        logic root_bad;
        logic look_done;
        logic sweep_done;
        logic scan_done;
        logic found;
        logic more;
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/gmef_ctrl.sv
// Controller state machine: sequences loads, edge lookup, selection rounds and result output.
`timescale 1ns / 1ps
`default_nettype none

module gmef_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [gmef_pkg::CMD_W-1:0] i_command,
    input  wire logic                      i_out_ready,
    input  wire gmef_pkg::t_dp_sts         i_sts,
    output gmef_pkg::t_dp_cmd              o_cmd,
    output logic                           o_in_ready,
    output logic                           o_out_valid
);

    gmef_pkg::t_state  r_state;
    gmef_pkg::t_state  n_state;
    gmef_pkg::t_cmd    w_cmd;

    assign w_cmd = gmef_pkg::t_cmd'(i_command);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmef_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            gmef_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_cmd)
                        gmef_pkg::CMD_LOAD_NODE: begin
                            if (i_sts.node_full) begin
                                o_cmd.ovf_set = 1'b1;
                            end else begin
                                o_cmd.node_wr = 1'b1;
                            end
                        end
                        gmef_pkg::CMD_LOAD_EDGE: begin
                            if (i_sts.edge_full) begin
                                o_cmd.ovf_set = 1'b1;
                            end else begin
                                o_cmd.edge_take = 1'b1;
                                n_state = gmef_pkg::S_LOOK;
                            end
                        end
                        gmef_pkg::CMD_START: begin
                            o_cmd.start_take = 1'b1;
                            if (i_sts.root_bad) begin
                                n_state = gmef_pkg::S_OUT;
                            end else begin
                                n_state = gmef_pkg::S_CLR;
                            end
                        end
                        gmef_pkg::CMD_CLEAR: begin
                            o_cmd.clr_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // resolve edge endpoints against the id store
            gmef_pkg::S_LOOK: begin
                if (i_sts.look_done) begin
                    o_cmd.edge_wr = 1'b1;
                    n_state = gmef_pkg::S_IDLE;
                end else begin
                    o_cmd.look_run = 1'b1;
                end
            end
            // chosen set := root alone
            gmef_pkg::S_CLR: begin
                if (i_sts.sweep_done) begin
                    n_state = gmef_pkg::S_NEXT;
                end else begin
                    o_cmd.sweep_run = 1'b1;
                end
            end
            gmef_pkg::S_NEXT: begin
                if (i_sts.more) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = gmef_pkg::S_SCAN;
                end else begin
                    n_state = gmef_pkg::S_RD;
                end
            end
            // one pass over the edge store per selection round; a pass adds at most one node
            gmef_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        o_cmd.pick = 1'b1;
                        n_state = gmef_pkg::S_NEXT;
                    end else begin
                        n_state = gmef_pkg::S_RD;
                    end
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            gmef_pkg::S_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = gmef_pkg::S_OUT;
            end
            gmef_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = gmef_pkg::S_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state = gmef_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = gmef_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/gmef_dp.sv
// Datapath: id and edge stores, endpoint lookup, chosen set, edge scan and result list.
`timescale 1ns / 1ps
`default_nettype none

module gmef_dp #(
    parameter int MAX_NODES = gmef_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gmef_pkg::MAX_EDGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gmef_pkg::t_dp_cmd             i_cmd,
    output gmef_pkg::t_dp_sts                  o_sts,
    input  wire logic                          i_cfg_valid,
    input  wire logic [gmef_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_node_id,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_from_id,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_to_id,
    input  wire logic [gmef_pkg::WT_W-1:0]     i_edge_weight,
    input  wire logic [gmef_pkg::ROOT_W-1:0]   i_root_index,
    output logic [gmef_pkg::NIDX_W-1:0]        o_node_index,
    output logic [gmef_pkg::POS_W-1:0]         o_position,
    output logic                               o_last,
    output logic [gmef_pkg::STAT_W-1:0]        o_status
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int RCW = (NCW > gmef_pkg::ROOT_W) ? NCW : gmef_pkg::ROOT_W;
    localparam int CW  = gmef_pkg::CNT_W;

    // Counters and configuration
    logic [NCW-1:0]                   r_node_count;
    logic [ECW-1:0]                   r_edge_count;
    logic                             r_ovf;
    logic [gmef_pkg::LIMIT_W-1:0]     r_limit;
    logic [CW-1:0]                    r_lim;
    logic [CW-1:0]                    r_count;

    // Latched item fields
    logic [gmef_pkg::ID_W-1:0]        r_from;
    logic [gmef_pkg::ID_W-1:0]        r_to;
    logic [gmef_pkg::WT_W-1:0]        r_wt;
    logic [NW-1:0]                    r_root;
    logic                             r_bad;

    // Stores
    logic [gmef_pkg::ID_W-1:0]        r_id_mem   [MAX_NODES];
    logic                             r_live_mem [MAX_EDGES];
    logic [NW-1:0]                    r_src_mem  [MAX_EDGES];
    logic [NW-1:0]                    r_tgt_mem  [MAX_EDGES];
    logic [gmef_pkg::WT_W-1:0]        r_wt_mem   [MAX_EDGES];
    logic                             r_chosen   [MAX_NODES];
    logic [NW-1:0]                    r_order    [gmef_pkg::RESULT_CAP];

    // Lookup pipeline
    logic [NCW-1:0]                   r_j;
    logic                             r_lk_vld;
    logic [NW-1:0]                    r_lk_idx;
    logic [gmef_pkg::ID_W-1:0]        r_id_q;
    logic                             r_src_ok;
    logic                             r_tgt_ok;
    logic [NW-1:0]                    r_src_idx;
    logic [NW-1:0]                    r_tgt_idx;
    logic                             w_look_issue;

    // Sweep and scan pipeline
    logic [NCW-1:0]                   r_a;
    logic [ECW-1:0]                   r_e;
    logic                             w_scan_issue;
    logic                             r_sa_vld;
    logic                             r_sa_live;
    logic [NW-1:0]                    r_sa_src;
    logic [NW-1:0]                    r_sa_tgt;
    logic [gmef_pkg::WT_W-1:0]        r_sa_wt;
    logic                             r_sb_vld;
    logic                             r_sb_live;
    logic [NW-1:0]                    r_sb_tgt;
    logic [gmef_pkg::WT_W-1:0]        r_sb_wt;
    logic                             r_cs_q;
    logic                             r_ct_q;
    logic                             r_found;
    logic [NW-1:0]                    r_best_tgt;
    logic [gmef_pkg::WT_W-1:0]        r_best_wt;

    // Output side
    logic [gmef_pkg::POS_W-1:0]       r_k;
    logic [NW-1:0]                    r_order_q;
    gmef_pkg::t_status                w_status;

    assign w_look_issue = i_cmd.look_run && (r_j < r_node_count);
    assign w_scan_issue = i_cmd.scan_run && (r_e < r_edge_count);

    // Status to controller
    always_comb begin
        o_sts.node_full  = (r_node_count == NCW'(MAX_NODES));
        o_sts.edge_full  = (r_edge_count == ECW'(MAX_EDGES));
        o_sts.root_bad   = (RCW'(i_root_index) >= RCW'(r_node_count));
        o_sts.look_done  = (r_j == r_node_count) && !r_lk_vld;
        o_sts.sweep_done = (r_a == NCW'(MAX_NODES));
        o_sts.scan_done  = (r_e == r_edge_count) && !r_sa_vld && !r_sb_vld;
        o_sts.found      = r_found;
        o_sts.more       = (r_count < r_lim);
        o_sts.last       = r_bad || ((CW'(r_k) + CW'(1)) == r_count);
    end

    // Control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_edge_count <= '0;
            r_ovf        <= 1'b0;
            r_limit      <= gmef_pkg::LIMIT_W'(1);
            r_lim        <= CW'(1);
            r_count      <= '0;
            r_bad        <= 1'b0;
            r_j          <= '0;
            r_lk_vld     <= 1'b0;
            r_a          <= '0;
            r_e          <= '0;
            r_sa_vld     <= 1'b0;
            r_sb_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_k          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clr_all) begin
                r_node_count <= '0;
                r_edge_count <= '0;
                r_ovf        <= 1'b0;
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.node_wr) begin
                r_node_count <= r_node_count + NCW'(1);
            end
            if (i_cmd.edge_wr) begin
                r_edge_count <= r_edge_count + ECW'(1);
            end
            // lookup issue counter
            if (i_cmd.edge_take) begin
                r_j <= '0;
            end else if (w_look_issue) begin
                r_j <= r_j + NCW'(1);
            end
            r_lk_vld <= w_look_issue;
            // selection start: clamp limit, root is chosen first
            if (i_cmd.start_take) begin
                r_bad   <= o_sts.root_bad;
                r_k     <= '0;
                r_a     <= '0;
                r_count <= CW'(1);
                if (r_limit == '0) begin
                    r_lim <= CW'(1);
                end else if (CW'(r_limit) > CW'(gmef_pkg::RESULT_CAP)) begin
                    r_lim <= CW'(gmef_pkg::RESULT_CAP);
                end else begin
                    r_lim <= CW'(r_limit);
                end
            end
            if (i_cmd.sweep_run) begin
                r_a <= r_a + NCW'(1);
            end
            // scan issue and best tracking
            if (i_cmd.scan_start) begin
                r_e     <= '0;
                r_found <= 1'b0;
            end else begin
                if (w_scan_issue) begin
                    r_e <= r_e + ECW'(1);
                end
                if (r_sb_vld && r_sb_live && r_cs_q && !r_ct_q &&
                    (!r_found || (r_sb_wt > r_best_wt))) begin
                    r_found <= 1'b1;
                end
            end
            r_sa_vld <= w_scan_issue;
            r_sb_vld <= r_sa_vld;
            if (i_cmd.pick) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out_next) begin
                r_k <= r_k + gmef_pkg::POS_W'(1);
            end
        end
    end

    // Item field capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_take) begin
            r_from <= i_from_id;
            r_to   <= i_to_id;
            r_wt   <= i_edge_weight;
        end
        if (i_cmd.start_take) begin
            r_root <= NW'(i_root_index);
        end
    end

    // Id store: write on node load, one read per lookup step
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr) begin
            r_id_mem[r_node_count[NW-1:0]] <= i_node_id;
        end
        if (w_look_issue) begin
            r_id_q <= r_id_mem[r_j[NW-1:0]];
        end
    end

    // Endpoint match: first stored position wins
    always_ff @(posedge i_clk) begin
        r_lk_idx <= r_j[NW-1:0];
        if (i_cmd.edge_take) begin
            r_src_ok  <= 1'b0;
            r_tgt_ok  <= 1'b0;
            r_src_idx <= '0;
            r_tgt_idx <= '0;
        end else if (r_lk_vld) begin
            if (!r_src_ok && (r_id_q == r_from)) begin
                r_src_ok  <= 1'b1;
                r_src_idx <= r_lk_idx;
            end
            if (!r_tgt_ok && (r_id_q == r_to)) begin
                r_tgt_ok  <= 1'b1;
                r_tgt_idx <= r_lk_idx;
            end
        end
    end

    // Edge store: write after lookup, one read per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr) begin
            r_live_mem[r_edge_count[EAW-1:0]] <= r_src_ok && r_tgt_ok;
            r_src_mem[r_edge_count[EAW-1:0]]  <= r_src_idx;
            r_tgt_mem[r_edge_count[EAW-1:0]]  <= r_tgt_idx;
            r_wt_mem[r_edge_count[EAW-1:0]]   <= r_wt;
        end
        if (w_scan_issue) begin
            r_sa_live <= r_live_mem[r_e[EAW-1:0]];
            r_sa_src  <= r_src_mem[r_e[EAW-1:0]];
            r_sa_tgt  <= r_tgt_mem[r_e[EAW-1:0]];
            r_sa_wt   <= r_wt_mem[r_e[EAW-1:0]];
        end
    end

    // Chosen set: one write port (sweep or pick), reads at source and target
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_run) begin
            r_chosen[r_a[NW-1:0]] <= (r_a[NW-1:0] == r_root);
        end else if (i_cmd.pick) begin
            r_chosen[r_best_tgt] <= 1'b1;
        end
        if (r_sa_vld) begin
            r_cs_q <= r_chosen[r_sa_src];
            r_ct_q <= r_chosen[r_sa_tgt];
        end
        r_sb_live <= r_sa_live;
        r_sb_tgt  <= r_sa_tgt;
        r_sb_wt   <= r_sa_wt;
    end

    // Best frontier edge of the current round
    always_ff @(posedge i_clk) begin
        if (!i_cmd.scan_start && r_sb_vld && r_sb_live && r_cs_q && !r_ct_q &&
            (!r_found || (r_sb_wt > r_best_wt))) begin
            r_best_tgt <= r_sb_tgt;
            r_best_wt  <= r_sb_wt;
        end
    end

    // Result list in order of choice
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_take) begin
            r_order[0] <= NW'(i_root_index);
        end else if (i_cmd.pick) begin
            r_order[r_count[gmef_pkg::POS_W-1:0]] <= r_best_tgt;
        end
        if (i_cmd.out_rd) begin
            r_order_q <= r_order[r_k];
        end
    end

    // Result fields
    always_comb begin
        if (r_bad) begin
            w_status = gmef_pkg::STAT_ROOT_BAD;
        end else if (r_ovf) begin
            w_status = gmef_pkg::STAT_OVERFLOW;
        end else begin
            w_status = gmef_pkg::STAT_OK;
        end
    end

    assign o_node_index = r_bad ? '0 : gmef_pkg::NIDX_W'(r_order_q);
    assign o_position   = r_k;
    assign o_last       = o_sts.last;
    assign o_status     = w_status;

endmodule

`default_nettype wire

// File: rtl/greedy_max_edge_frontier_growth_core.sv
// Top level of the greedy max-edge frontier growth block: controller plus datapath.
//
//  channel   valid         ready         payload
//  -------   -----------   -----------   -------------------------------------------------
//  in        i_in_valid    o_in_ready    i_command i_node_id i_from_id i_to_id
//                                         i_edge_weight i_root_index
//  out       o_out_valid   i_out_ready   o_node_index o_position o_last o_status
//  cfg       i_cfg_valid   o_cfg_ready   i_cfg_data (node_limit)
//
// Node load and clear items are taken in the idle state; an edge load walks the id store
// one entry per cycle to resolve its endpoints before the edge is written.
// A start item sweeps the chosen set, then runs one pass over the edge store per added node,
// plus a last one that finds none if the frontier runs dry, then reads out and offers
// each result in turn.
// Reset is synchronous, active low; it clears counters, flags and node_limit (to 1).
// One item is in work at a time; the output holds its item until i_out_ready.
`timescale 1ns / 1ps
`default_nettype none

module greedy_max_edge_frontier_growth_core #(
    parameter int MAX_NODES = gmef_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gmef_pkg::MAX_EDGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [gmef_pkg::CMD_W-1:0]    i_command,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_node_id,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_from_id,
    input  wire logic [gmef_pkg::ID_W-1:0]     i_to_id,
    input  wire logic [gmef_pkg::WT_W-1:0]     i_edge_weight,
    input  wire logic [gmef_pkg::ROOT_W-1:0]   i_root_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [gmef_pkg::NIDX_W-1:0]        o_node_index,
    output logic [gmef_pkg::POS_W-1:0]         o_position,
    output logic                               o_last,
    output logic [gmef_pkg::STAT_W-1:0]        o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gmef_pkg::LIMIT_W-1:0]  i_cfg_data
);

    gmef_pkg::t_dp_cmd w_cmd;
    gmef_pkg::t_dp_sts w_sts;
    logic              w_cfg_wr;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    gmef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    gmef_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (w_cfg_wr),
        .i_cfg_data    (i_cfg_data),
        .i_node_id     (i_node_id),
        .i_from_id     (i_from_id),
        .i_to_id       (i_to_id),
        .i_edge_weight (i_edge_weight),
        .i_root_index  (i_root_index),
        .o_node_index  (o_node_index),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// File: bench/greedy_max_edge_frontier_growth_core_test.sv
// Self-checking bench for the greedy max-edge frontier growth core: directed table plus random graphs.
`timescale 1ns / 1ps

module greedy_max_edge_frontier_growth_core_test;
    import gmef_pkg::*;

    localparam int NODE_CAP = MAX_NODES_DEF;
    localparam int EDGE_CAP = MAX_EDGES_DEF;

    // One input item as offered to the block
    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   node_id;
        logic [ID_W-1:0]   from_id;
        logic [ID_W-1:0]   to_id;
        logic [WT_W-1:0]   weight;
        logic [ROOT_W-1:0] root;
    } stim_t;

    // One chosen-node result
    typedef struct packed {
        logic [NIDX_W-1:0] node_idx;
        logic [POS_W-1:0]  pos;
        logic              last;
        t_status           status;
    } pick_t;

    // Directed row: an item, or a node_limit write when is_cfg is set
    typedef struct packed {
        logic               is_cfg;
        t_cmd               cmd;
        logic [ID_W-1:0]    id_a;   // node id, or edge source id
        logic [ID_W-1:0]    id_b;   // edge target id
        logic [WT_W-1:0]    wt;
        logic [ROOT_W-1:0]  root;
        logic [LIMIT_W-1:0] lim;
        logic               typed;  // want holds the single expected result
        pick_t              want;
    } dir_row_t;

    localparam logic [ID_W-1:0] ID_TOP = '1;
    localparam logic [WT_W-1:0] WT_TOP = '1;
    localparam pick_t NO_PICK   = '0;
    localparam pick_t BAD_ROOT  = '{6'd0, 6'd0, 1'b1, STAT_ROOT_BAD};
    localparam pick_t ROOT_ZERO = '{6'd0, 6'd0, 1'b1, STAT_OK};

    // Four nodes (index 3 repeats id 0), a few edges with ties and unknown ids
    localparam dir_row_t DIR_TAB [24] = '{
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd0,  7'd0,   1'b1, BAD_ROOT},
        '{1'b0, CMD_LOAD_NODE, 63'd0,  '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_NODE, ID_TOP, '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_NODE, 63'd5,  '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_NODE, 63'd0,  '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd0,  7'd0,   1'b1, ROOT_ZERO},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd4,  7'd0,   1'b1, BAD_ROOT},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd63, 7'd0,   1'b1, BAD_ROOT},
        '{1'b0, CMD_LOAD_EDGE, 63'd0,  ID_TOP, WT_TOP, 6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_EDGE, ID_TOP, 63'd5,  '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_EDGE, 63'd0,  63'd5,  WT_TOP, 6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_EDGE, 63'd5,  63'd0,  32'd7,  6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_EDGE, 63'd0,  63'd999, WT_TOP, 6'd0, 7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_LOAD_EDGE, 63'd123, 63'd5, 32'd9,  6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b1, CMD_LOAD_NODE, '0,     '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd0,  7'd0,   1'b1, ROOT_ZERO},
        '{1'b1, CMD_LOAD_NODE, '0,     '0,     '0,     6'd0,  7'd127, 1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd2,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd3,  7'd0,   1'b0, NO_PICK},
        '{1'b1, CMD_LOAD_NODE, '0,     '0,     '0,     6'd0,  7'd2,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd1,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_CLEAR,     '0,     '0,     '0,     6'd0,  7'd0,   1'b0, NO_PICK},
        '{1'b0, CMD_START,     '0,     '0,     '0,     6'd0,  7'd0,   1'b1, BAD_ROOT}
    };

    // Block ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_command = '0;
    logic [ID_W-1:0]     i_node_id = '0;
    logic [ID_W-1:0]     i_from_id = '0;
    logic [ID_W-1:0]     i_to_id = '0;
    logic [WT_W-1:0]     i_edge_weight = '0;
    logic [ROOT_W-1:0]   i_root_index = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [NIDX_W-1:0]   o_node_index;
    logic [POS_W-1:0]    o_position;
    logic                o_last;
    logic [STAT_W-1:0]   o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_data = '0;

    // Predictor state
    logic [ID_W-1:0]     known_ids [NODE_CAP];
    int unsigned         nodes_held = 0;
    int unsigned         edge_src [EDGE_CAP];
    int unsigned         edge_dst [EDGE_CAP];
    logic [WT_W-1:0]     edge_wt [EDGE_CAP];
    bit                  edge_live [EDGE_CAP];
    int unsigned         edges_held = 0;
    bit                  lost_load = 1'b0;
    logic [LIMIT_W-1:0]  grow_limit = 7'd1;

    // Expected chosen nodes, oldest first
    pick_t               pending_picks [$];
    int unsigned         bad_fields = 0;
    int unsigned         in_calm = 0;
    int unsigned         out_calm = 0;
    bit                  hold_off_armed = 1'b0;

    greedy_max_edge_frontier_growth_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_node_id     (i_node_id),
        .i_from_id     (i_from_id),
        .i_to_id       (i_to_id),
        .i_edge_weight (i_edge_weight),
        .i_root_index  (i_root_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_node_index  (o_node_index),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle cycles before an item; now and then a stretch with none
    function automatic int unsigned draw_gap(ref int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'({$urandom, $urandom});
    endfunction

    // Every field random, the command too
    function automatic stim_t rand_stim();
        stim_t it;
        it.cmd     = t_cmd'($urandom_range(0, 3));
        it.node_id = rand_id();
        it.from_id = rand_id();
        it.to_id   = rand_id();
        it.weight  = $urandom;
        it.root    = ROOT_W'($urandom_range(0, 63));
        return it;
    endfunction

    // Load position of the first stored node with this id
    function automatic bit find_first_id(input logic [ID_W-1:0] id, output int unsigned pos);
        int unsigned i;
        pos = 0;
        for (i = 0; i < nodes_held; i++) begin
            if (known_ids[i] == id) begin
                pos = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one item to the predictor; returns the chosen nodes it yields
    function automatic void predict_growth(input stim_t it, ref pick_t picks[$]);
        int unsigned src, dst, lim, cnt, best, i;
        bit          ok_src, ok_dst, found;
        bit [NODE_CAP-1:0] in_tree;
        int unsigned order [RESULT_CAP];
        pick_t       p;
        picks.delete();
        case (it.cmd)
            CMD_LOAD_NODE: begin
                if (nodes_held < NODE_CAP) begin
                    known_ids[nodes_held] = it.node_id;
                    nodes_held++;
                end else begin
                    lost_load = 1'b1;
                end
            end
            CMD_LOAD_EDGE: begin
                if (edges_held >= EDGE_CAP) begin
                    lost_load = 1'b1;
                end else begin
                    ok_src = find_first_id(it.from_id, src);
                    ok_dst = find_first_id(it.to_id, dst);
                    edge_src[edges_held]  = src;
                    edge_dst[edges_held]  = dst;
                    edge_wt[edges_held]   = it.weight;
                    edge_live[edges_held] = ok_src && ok_dst;
                    edges_held++;
                end
            end
            CMD_CLEAR: begin
                nodes_held = 0;
                edges_held = 0;
                lost_load  = 1'b0;
            end
            CMD_START: begin
                if (it.root >= nodes_held) begin
                    picks.push_back(BAD_ROOT);
                end else begin
                    // zero acts as one, above the cap acts as the cap
                    lim = (grow_limit == 0) ? 1 : grow_limit;
                    if (lim > RESULT_CAP) lim = RESULT_CAP;
                    in_tree = '0;
                    in_tree[it.root] = 1'b1;
                    order[0] = it.root;
                    cnt = 1;
                    while (cnt < lim) begin
                        found = 1'b0;
                        best  = 0;
                        // strictly greater weight wins, so ties keep the earliest edge
                        for (i = 0; i < edges_held; i++) begin
                            if (edge_live[i] && in_tree[edge_src[i]] && !in_tree[edge_dst[i]] &&
                                (!found || edge_wt[i] > edge_wt[best])) begin
                                best  = i;
                                found = 1'b1;
                            end
                        end
                        if (!found) break;
                        in_tree[edge_dst[best]] = 1'b1;
                        order[cnt] = edge_dst[best];
                        cnt++;
                    end
                    for (i = 0; i < cnt; i++) begin
                        p.node_idx = NIDX_W'(order[i]);
                        p.pos      = POS_W'(i);
                        p.last     = (i + 1 == cnt);
                        p.status   = lost_load ? STAT_OVERFLOW : STAT_OK;
                        picks.push_back(p);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one item; valid stays up afterwards until the next offer or settle
    task automatic offer_item(input stim_t it, input bit typed, input pick_t want);
        pick_t       got [$];
        int unsigned gap;
        gap = draw_gap(in_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= it.cmd;
        i_node_id     <= it.node_id;
        i_from_id     <= it.from_id;
        i_to_id       <= it.to_id;
        i_edge_weight <= it.weight;
        i_root_index  <= it.root;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_growth(it, got);
        if (typed) pending_picks.push_back(want);
        else foreach (got[k]) pending_picks.push_back(got[k]);
    endtask

    // Now and then a fully random item between well-formed ones
    task automatic offer_noise();
        if ($urandom_range(0, 11) == 0) offer_item(rand_stim(), 1'b0, NO_PICK);
    endtask

    // Drain all results, then let a last load finish its id walk
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_node_limit(input logic [LIMIT_W-1:0] lim);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        grow_limit = lim;
    endtask

    // Result side: random stalls, one long hold-off on request, field checks
    initial begin : result_side
        pick_t       want;
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_armed) begin
                hold_off_armed = 1'b0;
                i_out_ready <= 1'b0;
                // let a result show up, then keep it waiting
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
                repeat (600) @(posedge i_clk);
            end
            gap = draw_gap(out_calm);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid && !hold_off_armed) @(posedge i_clk);
            if (o_out_valid) begin
                if (pending_picks.size() == 0) begin
                    $error("result with none expected: node_index %0d position %0d",
                           o_node_index, o_position);
                    bad_fields++;
                end else begin
                    want = pending_picks.pop_front();
                    if (o_node_index !== want.node_idx) begin
                        $error("node_index expected %0d got %0d", want.node_idx, o_node_index);
                        bad_fields++;
                    end
                    if (o_position !== want.pos) begin
                        $error("position expected %0d got %0d", want.pos, o_position);
                        bad_fields++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, o_last);
                        bad_fields++;
                    end
                    if (o_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_status);
                        bad_fields++;
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin : item_side
        stim_t             it;
        logic [ID_W-1:0]   fill_ids [NODE_CAP + 1];
        logic [ID_W-1:0]   id_pool [10];
        logic [LIMIT_W-1:0] lim;
        int unsigned       n_nodes, n_edges, n_starts, i, j;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (i = 0; i < $size(DIR_TAB); i++) begin
            if (DIR_TAB[i].is_cfg) begin
                set_node_limit(DIR_TAB[i].lim);
            end else begin
                it         = '0;
                it.cmd     = DIR_TAB[i].cmd;
                it.node_id = DIR_TAB[i].id_a;
                it.from_id = DIR_TAB[i].id_a;
                it.to_id   = DIR_TAB[i].id_b;
                it.weight  = DIR_TAB[i].wt;
                it.root    = DIR_TAB[i].root;
                offer_item(it, DIR_TAB[i].typed, DIR_TAB[i].want);
            end
        end

        // Fill both stores past capacity; the extra node is dropped, but edges still name its id
        set_node_limit(7'd127);
        it = rand_stim();
        it.cmd = CMD_CLEAR;
        offer_item(it, 1'b0, NO_PICK);
        for (i = 0; i <= NODE_CAP; i++) begin
            fill_ids[i] = (i > 0 && $urandom_range(0, 7) == 0) ?
                          fill_ids[$urandom_range(0, i - 1)] : rand_id();
            it = rand_stim();
            it.cmd = CMD_LOAD_NODE;
            it.node_id = fill_ids[i];
            offer_item(it, 1'b0, NO_PICK);
        end
        for (i = 0; i <= EDGE_CAP; i++) begin
            it = rand_stim();
            it.cmd = CMD_LOAD_EDGE;
            it.from_id = fill_ids[$urandom_range(0, NODE_CAP)];
            it.to_id   = fill_ids[$urandom_range(0, NODE_CAP)];
            if ($urandom_range(0, 1) == 0) it.weight = WT_W'($urandom_range(0, 15));
            offer_item(it, 1'b0, NO_PICK);
        end
        it = rand_stim();
        it.cmd = CMD_START;
        offer_item(it, 1'b0, NO_PICK);
        // long receiver hold-off while more items queue up behind a full selection
        hold_off_armed = 1'b1;
        it = rand_stim();
        it.cmd = CMD_START;
        offer_item(it, 1'b0, NO_PICK);
        it = rand_stim();
        it.cmd = CMD_LOAD_NODE;
        offer_item(it, 1'b0, NO_PICK);
        it.cmd = CMD_LOAD_EDGE;
        offer_item(it, 1'b0, NO_PICK);
        it = rand_stim();
        it.cmd = CMD_START;
        offer_item(it, 1'b0, NO_PICK);

        // Random graphs: clear, nodes, edges, then a few selections
        for (i = 0; i < 6; i++) begin
            case ($urandom_range(0, 7))
                0:       lim = 7'd0;
                1:       lim = 7'd1;
                2:       lim = 7'd64;
                3:       lim = 7'd127;
                4:       lim = 7'd65;
                default: lim = LIMIT_W'($urandom_range(2, 12));
            endcase
            set_node_limit(lim);
            // small ids collide often; some pool ids never get loaded
            for (j = 0; j < 10; j++)
                id_pool[j] = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 15)) : rand_id();
            it = rand_stim();
            it.cmd = CMD_CLEAR;
            offer_item(it, 1'b0, NO_PICK);

            n_nodes = $urandom_range(1, 10);
            for (j = 0; j < n_nodes; j++) begin
                it = rand_stim();
                it.cmd = CMD_LOAD_NODE;
                it.node_id = id_pool[$urandom_range(0, 9)];
                offer_item(it, 1'b0, NO_PICK);
                offer_noise();
            end

            n_edges = $urandom_range(0, 16);
            for (j = 0; j < n_edges; j++) begin
                it = rand_stim();
                it.cmd = CMD_LOAD_EDGE;
                if ($urandom_range(0, 11) != 0) it.from_id = id_pool[$urandom_range(0, 9)];
                if ($urandom_range(0, 11) != 0) it.to_id = id_pool[$urandom_range(0, 9)];
                if ($urandom_range(0, 1) == 0) it.weight = WT_W'($urandom_range(0, 3));
                offer_item(it, 1'b0, NO_PICK);
                offer_noise();
            end

            n_starts = $urandom_range(1, 3);
            for (j = 0; j < n_starts; j++) begin
                it = rand_stim();
                it.cmd = CMD_START;
                if (nodes_held != 0 && $urandom_range(0, 5) != 0)
                    it.root = ROOT_W'($urandom_range(0, nodes_held - 1));
                offer_item(it, 1'b0, NO_PICK);
                offer_noise();
            end
        end

        settle();
        if (bad_fields == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit: far beyond the slowest correct run
    initial begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: greedy_max_edge_frontier_growth_core.f
rtl/gmef_pkg.sv
rtl/gmef_ctrl.sv
rtl/gmef_dp.sv
rtl/greedy_max_edge_frontier_growth_core.sv
bench/greedy_max_edge_frontier_growth_core_test.sv
